>>> hw/rtl/xcfr_pkg.sv
`timescale 1ns / 1ps

package xcfr_pkg;

  localparam int unsigned MAX_PAYLOAD = 2;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_CMD  = 3'd1;
  localparam logic [2:0] PH_LEN  = 3'd2;
  localparam logic [2:0] PH_BODY = 3'd3;
  localparam logic [2:0] PH_END  = 3'd4;

  localparam logic EV_ACK   = 1'b0;
  localparam logic EV_FRAME = 1'b1;

  localparam logic CFG_START = 1'b0;
  localparam logic CFG_END   = 1'b1;

  localparam logic [7:0] START_MARKER_RST = 8'h7F;
  localparam logic [7:0] END_MARKER_RST   = 8'h7E;

  typedef struct packed {
    logic       event_kind;
    logic [7:0] frame_cmd;
    logic [1:0] payload_len;
    logic [7:0] payload_first;
    logic [7:0] payload_second;
  } res_t;

endpackage

>>> hw/rtl/xcfr_parse.sv
`timescale 1ns / 1ps

module xcfr_parse import xcfr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] rx_byte,
  input  logic [7:0] start_marker,
  input  logic [7:0] end_marker,
  output logic       res_valid,
  output res_t       res
);

  logic [2:0] phase_r, phase_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [1:0] len_r, len_nxt;
  logic [2:0] count_r, count_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] check_r;
  logic [7:0] store_r [MAX_PAYLOAD];

  logic       store_we;
  logic       check_we;
  logic [2:0] body_end;

  assign body_end = {1'b0, len_r} + 3'd2;

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    count_nxt = count_r;
    xor_nxt   = xor_r;
    store_we  = 1'b0;
    check_we  = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    if (rx_byte == start_marker) begin
      phase_nxt      = PH_CMD;
      res_valid      = 1'b1;
      res.event_kind = EV_ACK;
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
        end
        PH_CMD: begin
          cmd_nxt   = rx_byte;
          xor_nxt   = rx_byte;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          if (rx_byte > 8'(MAX_PAYLOAD)) begin
            phase_nxt = PH_IDLE;
          end else begin
            len_nxt   = rx_byte[1:0];
            xor_nxt   = xor_r ^ rx_byte;
            count_nxt = 3'd0;
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          if (count_r < {1'b0, len_r}) begin
            store_we = 1'b1;
            xor_nxt  = xor_r ^ rx_byte;
          end else if (count_r == {1'b0, len_r}) begin
            check_we = 1'b1;
          end
          count_nxt = count_r + 3'd1;
          if (count_nxt >= body_end) begin
            phase_nxt = PH_END;
          end
        end
        PH_END: begin
          phase_nxt = PH_IDLE;
          if (rx_byte == end_marker && xor_r == check_r) begin
            res_valid          = 1'b1;
            res.event_kind     = EV_FRAME;
            res.frame_cmd      = cmd_r;
            res.payload_len    = len_r;
            res.payload_first  = (len_r >= 2'd1) ? store_r[0] : 8'd0;
            res.payload_second = (len_r >= 2'd2) ? store_r[1] : 8'd0;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cmd_r   <= '0;
      len_r   <= '0;
      count_r <= '0;
      xor_r   <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      count_r <= count_nxt;
      xor_r   <= xor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && store_we) begin
      store_r[count_r[0:0]] <= rx_byte;
    end
    if (take && check_we) begin
      check_r <= rx_byte;
    end
  end

endmodule

>>> hw/rtl/xor_checked_frame_receiver_unit.sv
`timescale 1ns / 1ps
// Frame receiver with XOR check, one byte word per cycle.
// A result is registered into out_*, or the skid stage when out is stalled.
// Throughput: one word per cycle; an output register plus skid stage keeps
// input flowing while a result waits; in_stall rises only when both are full.
// Reset (rst_n, synchronous, active low): parser idle, markers 0x7F / 0x7E.

module xor_checked_frame_receiver_unit import xcfr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_event_kind,
  output logic [7:0] out_frame_cmd,
  output logic [1:0] out_payload_len,
  output logic [7:0] out_payload_first,
  output logic [7:0] out_payload_second,
  input  logic       cfg_we,
  input  logic       cfg_addr,
  input  logic [7:0] cfg_wdata
);

  logic [7:0] start_marker_r;
  logic [7:0] end_marker_r;

  logic       take;
  logic       res_valid;
  res_t       res;

  logic       out_valid_r;
  res_t       out_r;
  logic       skid_valid_r;
  res_t       skid_r;
  logic       out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= START_MARKER_RST;
      end_marker_r   <= END_MARKER_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_START: start_marker_r <= cfg_wdata;
        CFG_END:   end_marker_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_stall = skid_valid_r;
  assign take     = in_valid && !skid_valid_r;

  xcfr_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .rx_byte      (in_rx_byte),
    .start_marker (start_marker_r),
    .end_marker   (end_marker_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  // output slot can be loaded when empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= take && res_valid;
      end
    end else if (take && res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (take && res_valid) begin
        out_r <= res;
      end
    end else if (take && res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_kind     = out_r.event_kind;
  assign out_frame_cmd      = out_r.frame_cmd;
  assign out_payload_len    = out_r.payload_len;
  assign out_payload_first  = out_r.payload_first;
  assign out_payload_second = out_r.payload_second;

endmodule
